// ----- src/hid_gamepad_report_decoder_core_defines.svh -----
// Assertion macros shared by the decoder core.
`ifndef HID_GAMEPAD_REPORT_DECODER_CORE_DEFINES_SVH
`define HID_GAMEPAD_REPORT_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock out of reset.
`define HGRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock out of reset.
`define HGRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/hgrd_pkg.sv -----
`timescale 1ns / 1ps

package hgrd_pkg;

    localparam int LEN_W    = 7;
    localparam int HDR_USED = 11;

    localparam logic [7:0] CENTER_LO = 8'h70;
    localparam logic [7:0] CENTER_HI = 8'h90;
    localparam logic [7:0] HAT_IDLE  = 8'h08;
    localparam logic [7:0] AXIS_LO   = 8'h20;
    localparam logic [7:0] AXIS_HI   = 8'hE0;
    localparam logic [7:0] ID_MAX    = 8'h0F;
    localparam logic [7:0] ID_MIN    = 8'h01;
    localparam logic [7:0] AXIS_MID  = 8'd128;

    localparam logic [3:0] DP_UP    = 4'b0001;
    localparam logic [3:0] DP_DOWN  = 4'b0010;
    localparam logic [3:0] DP_LEFT  = 4'b0100;
    localparam logic [3:0] DP_RIGHT = 4'b1000;

    typedef enum logic [1:0] {
        LAYOUT_UNKNOWN = 2'd0,
        LAYOUT_A       = 2'd1,
        LAYOUT_B       = 2'd2,
        LAYOUT_GENERIC = 2'd3
    } layout_t;

    typedef logic [HDR_USED-1:0][7:0] hdr_t;

    typedef struct packed {
        logic             valid;
        logic             disc;
        logic [LEN_W-1:0] len;
    } pend_t;

    typedef struct packed {
        logic              connected;
        logic [1:0]        layout;
        logic signed [7:0] left_x;
        logic signed [7:0] left_y;
        logic signed [7:0] right_x;
        logic signed [7:0] right_y;
        logic [3:0]        dpad;
        logic [13:0]       buttons;
        logic [9:0]        brake;
        logic [9:0]        throttle;
    } result_t;

    localparam logic [3:0] HAT_TABLE [8] = '{
        DP_UP, DP_UP | DP_RIGHT, DP_RIGHT, DP_DOWN | DP_RIGHT,
        DP_DOWN, DP_DOWN | DP_LEFT, DP_LEFT, DP_UP | DP_LEFT
    };

    function automatic logic [3:0] hat_dirs(input logic [3:0] hat);
        return hat[3] ? 4'b0000 : HAT_TABLE[hat[2:0]];
    endfunction

    function automatic logic [3:0] face_buttons(input logic [7:0] b);
        return {b[7], b[4], b[6], b[5]};
    endfunction

    function automatic logic [13:0] pad_buttons(input logic [7:0] b1, input logic [7:0] b2,
                                                input logic [7:0] b3);
        return {b3[1:0], b2, face_buttons(b1)};
    endfunction

    function automatic logic signed [7:0] stick(input logic [7:0] raw);
        return signed'(raw ^ AXIS_MID);
    endfunction

    function automatic logic centred(input logic [7:0] v);
        return (v >= CENTER_LO) && (v <= CENTER_HI);
    endfunction

endpackage

// ----- src/hgrd_capture.sv -----
`timescale 1ns / 1ps

module hgrd_capture #(
    parameter int MAX_REPORT_BYTES = 64,
    parameter int HEADER_BYTES     = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                take,
    input  logic                action,
    input  logic [7:0]          report_byte,
    input  logic                last_byte,
    output hgrd_pkg::pend_t     pend,
    output hgrd_pkg::hdr_t      hdr
);

    logic [hgrd_pkg::LEN_W-1:0] tally_reg, tally_next;
    logic [hgrd_pkg::LEN_W-1:0] len;
    hgrd_pkg::pend_t            pend_reg, pend_next;
    logic [7:0]                 hdr_reg [HEADER_BYTES];

    assign len = (tally_reg < hgrd_pkg::LEN_W'(MAX_REPORT_BYTES))
               ? tally_reg + hgrd_pkg::LEN_W'(1) : tally_reg;

    always_comb
    begin
        tally_next = tally_reg;
        pend_next  = pend_reg;
        if (take)
        begin
            pend_next.valid = 1'b0;
        end
        if (accept)
        begin
            if (action || last_byte)
            begin
                tally_next = '0;
            end
            else
            begin
                tally_next = len;
            end
            pend_next.disc = action;
            pend_next.len  = len;
            if (action || (last_byte && len >= hgrd_pkg::LEN_W'(4)))
            begin
                pend_next.valid = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
            pend_reg  <= '0;
        end
        else
        begin
            tally_reg <= tally_next;
            pend_reg  <= pend_next;
        end
    end

    for (genvar i = 0; i < HEADER_BYTES; i++)
    begin : g_store
        always_ff @(posedge clk)
        begin
            if (accept && !action && tally_reg == hgrd_pkg::LEN_W'(i))
            begin
                hdr_reg[i] <= report_byte;
            end
        end
    end

    for (genvar i = 0; i < hgrd_pkg::HDR_USED; i++)
    begin : g_hdr
        assign hdr[i] = hdr_reg[i];
    end

    assign pend = pend_reg;

endmodule

// ----- src/hgrd_decode.sv -----
`timescale 1ns / 1ps

module hgrd_decode (
    input  hgrd_pkg::hdr_t      hdr,
    input  hgrd_pkg::pend_t     pend,
    input  hgrd_pkg::layout_t   layout_cur,
    output hgrd_pkg::layout_t   layout_new,
    output hgrd_pkg::result_t   res
);

    hgrd_pkg::layout_t          chosen;
    hgrd_pkg::layout_t          lay;
    logic [3:0]                 h5, h8;
    logic                       idle_axes;
    logic                       off;
    logic [7:0]                 g [7];
    logic [3:0]                 dp;
    logic [13:0]                bt;

    assign h5 = hdr[5][3:0];
    assign h8 = hdr[8][3:0];
    assign idle_axes = hgrd_pkg::centred(hdr[1]) && hgrd_pkg::centred(hdr[2])
                    && hgrd_pkg::centred(hdr[3]) && hgrd_pkg::centred(hdr[4]);

    always_comb
    begin
        if (pend.len < hgrd_pkg::LEN_W'(10) || hdr[0] != hgrd_pkg::ID_MIN)
        begin
            chosen = hgrd_pkg::LAYOUT_GENERIC;
        end
        else if (idle_axes && hdr[5] == hgrd_pkg::HAT_IDLE && hdr[8] != hgrd_pkg::HAT_IDLE)
        begin
            chosen = hgrd_pkg::LAYOUT_A;
        end
        else if (idle_axes && hdr[5] == 8'h00 && hdr[8] == hgrd_pkg::HAT_IDLE)
        begin
            chosen = hgrd_pkg::LAYOUT_B;
        end
        else if (h5 <= 4'd8 && h8 > 4'd8)
        begin
            chosen = hgrd_pkg::LAYOUT_A;
        end
        else if (h8 <= 4'd8 && h5 > 4'd8)
        begin
            chosen = hgrd_pkg::LAYOUT_B;
        end
        else
        begin
            chosen = hgrd_pkg::LAYOUT_A;
        end
    end

    assign lay = (layout_cur == hgrd_pkg::LAYOUT_UNKNOWN) ? chosen : layout_cur;
    assign layout_new = pend.disc ? hgrd_pkg::LAYOUT_UNKNOWN : lay;

    assign off = pend.len > hgrd_pkg::LEN_W'(8)
              && hdr[0] >= hgrd_pkg::ID_MIN && hdr[0] <= hgrd_pkg::ID_MAX;

    for (genvar k = 0; k < 7; k++)
    begin : g_gen
        assign g[k] = off ? hdr[k+1] : hdr[k];
    end

    always_comb
    begin
        dp = '0;
        bt = '0;
        if (g[1] < hgrd_pkg::AXIS_LO) dp = dp | hgrd_pkg::DP_UP;
        if (g[1] > hgrd_pkg::AXIS_HI) dp = dp | hgrd_pkg::DP_DOWN;
        if (g[0] < hgrd_pkg::AXIS_LO) dp = dp | hgrd_pkg::DP_LEFT;
        if (g[0] > hgrd_pkg::AXIS_HI) dp = dp | hgrd_pkg::DP_RIGHT;
        if (pend.len >= hgrd_pkg::LEN_W'(6) + hgrd_pkg::LEN_W'(off))
        begin
            dp = dp | hgrd_pkg::hat_dirs(g[5][3:0]);
            bt[3:0] = hgrd_pkg::face_buttons(g[5]);
        end
        if (pend.len >= hgrd_pkg::LEN_W'(7) + hgrd_pkg::LEN_W'(off))
        begin
            bt[4] = g[6][0];
            bt[5] = g[6][1];
            bt[8] = g[6][4];
            bt[9] = g[6][5];
        end
    end

    always_comb
    begin
        res = '0;
        if (!pend.disc)
        begin
            res.connected = 1'b1;
            res.layout    = lay;
            case (lay)
                hgrd_pkg::LAYOUT_A:
                begin
                    if (pend.len >= hgrd_pkg::LEN_W'(10))
                    begin
                        res.left_x   = hgrd_pkg::stick(hdr[1]);
                        res.left_y   = hgrd_pkg::stick(hdr[2]);
                        res.right_x  = hgrd_pkg::stick(hdr[3]);
                        res.right_y  = hgrd_pkg::stick(hdr[4]);
                        res.dpad     = hgrd_pkg::hat_dirs(h5);
                        res.buttons  = hgrd_pkg::pad_buttons(hdr[5], hdr[6], hdr[7]);
                        res.brake    = {hdr[8], 2'b00};
                        res.throttle = {hdr[9], 2'b00};
                    end
                end
                hgrd_pkg::LAYOUT_B:
                begin
                    if (pend.len >= hgrd_pkg::LEN_W'(11))
                    begin
                        res.left_x   = hgrd_pkg::stick(hdr[1]);
                        res.left_y   = hgrd_pkg::stick(hdr[2]);
                        res.right_x  = hgrd_pkg::stick(hdr[3]);
                        res.right_y  = hgrd_pkg::stick(hdr[4]);
                        res.dpad     = hgrd_pkg::hat_dirs(h8);
                        res.buttons  = hgrd_pkg::pad_buttons(hdr[8], hdr[9], hdr[10]);
                        res.brake    = {hdr[5], 2'b00};
                        res.throttle = {hdr[6], 2'b00};
                    end
                end
                default:
                begin
                    res.left_x  = hgrd_pkg::stick(g[0]);
                    res.left_y  = hgrd_pkg::stick(g[1]);
                    res.right_x = hgrd_pkg::stick(g[2]);
                    res.right_y = hgrd_pkg::stick(g[3]);
                    res.dpad    = dp;
                    res.buttons = bt;
                end
            endcase
        end
    end

endmodule

// ----- src/hid_gamepad_report_decoder_core.sv -----
`timescale 1ns / 1ps
// A finished report waits in the capture register until the result register can take it.
// Throughput: one input word per cycle; capture register feeds a one-pass decode and result register.
// Input stalls only while a finished report or disconnect waits behind an unaccepted result word.
// Reset clears the byte count, the detected layout and both valid flags.
// The header byte store is not reset; it holds garbage until written.

`include "hid_gamepad_report_decoder_core_defines.svh"

module hid_gamepad_report_decoder_core #(
    parameter int MAX_REPORT_BYTES = 64,
    parameter int HEADER_BYTES     = 11
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [7:0]        report_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              connected,
    output logic [1:0]        layout,
    output logic signed [7:0] left_x,
    output logic signed [7:0] left_y,
    output logic signed [7:0] right_x,
    output logic signed [7:0] right_y,
    output logic [3:0]        dpad,
    output logic [13:0]       buttons,
    output logic [9:0]        brake,
    output logic [9:0]        throttle
);

    hgrd_pkg::pend_t   pend;
    hgrd_pkg::hdr_t    hdr;
    hgrd_pkg::layout_t layout_reg, layout_next, layout_new;
    hgrd_pkg::result_t res, res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              take;
    logic              accept;

    assign advance  = !out_valid_reg || out_ready;
    assign take     = pend.valid && advance;
    assign in_ready = !pend.valid || advance;
    assign accept   = in_valid && in_ready;

    hgrd_capture #(
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES),
        .HEADER_BYTES     (HEADER_BYTES)
    ) u_capture (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .take        (take),
        .action      (action),
        .report_byte (report_byte),
        .last_byte   (last_byte),
        .pend        (pend),
        .hdr         (hdr)
    );

    hgrd_decode u_decode (
        .hdr        (hdr),
        .pend       (pend),
        .layout_cur (layout_reg),
        .layout_new (layout_new),
        .res        (res)
    );

    always_comb
    begin
        layout_next    = layout_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            layout_next    = layout_new;
            res_next       = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg    <= hgrd_pkg::LAYOUT_UNKNOWN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            layout_reg    <= layout_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign connected = res_reg.connected;
    assign layout    = res_reg.layout;
    assign left_x    = res_reg.left_x;
    assign left_y    = res_reg.left_y;
    assign right_x   = res_reg.right_x;
    assign right_y   = res_reg.right_y;
    assign dpad      = res_reg.dpad;
    assign buttons   = res_reg.buttons;
    assign brake     = res_reg.brake;
    assign throttle  = res_reg.throttle;

    `HGRD_ASSERT_NOW(a_disc_zero, out_valid && !connected,
        layout == hgrd_pkg::LAYOUT_UNKNOWN && buttons == 14'd0 && dpad == 4'd0
        && brake == 10'd0,
        "disconnect word carries nonzero fields")
    `HGRD_ASSERT_NOW(a_conn_layout, out_valid && connected, layout != hgrd_pkg::LAYOUT_UNKNOWN,
        "connected word without a layout")
    `HGRD_ASSERT_NOW(a_generic_trig, out_valid && layout == hgrd_pkg::LAYOUT_GENERIC,
        brake == 10'd0 && throttle == 10'd0 && buttons[13:10] == 4'd0,
        "generic layout drives trigger or extra buttons")
    `HGRD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready,
        "input stalled while output side is free")
    `HGRD_ASSERT_NEXT(a_take_out, take, out_valid,
        "decoded report lost before the result register")

endmodule
